// ===== hw/rtl/qgus_pkg.sv =====
// ----------------------------------------------------------------------------
// qgus_pkg
// shared types and constants of the quota grant unit sizer
// ----------------------------------------------------------------------------
package qgus_pkg;

    localparam int QW     = 64;              // quantity width
    localparam int SW     = 16;              // slave count width
    localparam int IDXW   = 2;               // config register index width
    localparam int CFGW   = 64;              // config write data width
    localparam int DCNTW  = $clog2(QW);      // divider step counter width
    localparam int REMW   = SW + 2;          // divider partial remainder width

    localparam logic [IDXW-1:0] REG_LEAST_UNIT      = 2'd0;
    localparam logic [IDXW-1:0] REG_SOFT_LEAST_UNIT = 2'd1;
    localparam logic [IDXW-1:0] REG_SLAVE_COUNT     = 2'd2;
    localparam logic [IDXW-1:0] REG_BLOCK_RESOURCE  = 2'd3;

    localparam logic [QW-1:0] LEAST_UNIT_RST      = QW'(1048576);
    localparam logic [QW-1:0] SOFT_LEAST_UNIT_RST = QW'(4194304);

    localparam logic [1:0] REV_KEEP  = 2'd0;
    localparam logic [1:0] REV_CLEAR = 2'd1;
    localparam logic [1:0] REV_NOW   = 2'd2;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_SKIP  = 2'd1;
    localparam logic [1:0] ST_NOLIM = 2'd2;

    localparam logic OP_RESIZE = 1'b0;
    localparam logic OP_EXTRA  = 1'b1;

    typedef struct packed {
        logic [QW-1:0] least_unit;
        logic [QW-1:0] soft_least_unit;
        logic [SW-1:0] slave_count;
        logic          block_resource;
    } t_cfg;

    typedef enum logic [4:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_SETUP,
        CMD_MUL,
        CMD_SUM,
        CMD_SET_GROW,
        CMD_GROW,
        CMD_SHRINK,
        CMD_DIV_INIT,
        CMD_DIV_STEP,
        CMD_SET_CAP,
        CMD_CLAMP,
        CMD_SUB_TOT,
        CMD_MASK_GOT,
        CMD_SUB_HALF,
        CMD_GIVE,
        CMD_FIN_SKIP,
        CMD_FIN_NOLIM,
        CMD_FIN_RESIZE,
        CMD_FIN_EXP,
        CMD_FIN_ZERO
    } t_cmd;

    typedef struct packed {
        logic op;
        logic dir;            // 1 growing, 0 shrinking
        logic skip;
        logic nolim;
        logic soft_set;
        logic lim_zero;
        logic tot_ge_lim;
        logic decide_grow;
        logic grow_go;
        logic shrink_go;
        logic unit_zero;
        logic spare_ge_unit;
        logic left_gt_half;
        logic unit_ne_least;
        logic unit_ge_least;
    } t_stat;

endpackage

// ===== hw/rtl/quota_grant_unit_sizer.sv =====
// ----------------------------------------------------------------------------
// quota_grant_unit_sizer
// resizes a quota grant unit (opcode 0) or sizes an extra grant (opcode 1)
// ----------------------------------------------------------------------------
// usage:
//  - the user must write config regs via i_cfg_we / i_cfg_idx / i_cfg_data
//    only while the block is idle, which it does not enforce; index 0 least
//    unit, 1 soft least unit, 2 slave count, 3 block resource flag
//  - an item beat is taken when start is high and busy is low; all fields
//    are sampled in that cycle
//  - one result beat per item, shown for a single cycle with o_done high;
//    the receiver cannot stall, the result registers hold until the next one
//  - skipped, no-limit and exhausted items end straight after the checks,
//    otherwise each grow/shrink step of the unit takes one multiply, one
//    add and one compare, and a bit-serial division runs when the unit
//    overflows; one item at a time, the next item can be taken at the edge
//    that ends the result
//  - extra grant: the unit is quartered step by step
//  - reset loads the register defaults and returns the sequencer to idle
// ----------------------------------------------------------------------------
module quota_grant_unit_sizer import qgus_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    output logic            o_done,
    input  logic            i_cfg_we,
    input  logic [IDXW-1:0] i_cfg_idx,
    input  logic [CFGW-1:0] i_cfg_data,
    input  logic            i_opcode,
    input  logic            i_enforced,
    input  logic            i_root_id,
    input  logic [QW-1:0]   i_hard_limit,
    input  logic [QW-1:0]   i_soft_limit,
    input  logic [QW-1:0]   i_granted_total,
    input  logic [QW-1:0]   i_current_unit,
    input  logic [QW-1:0]   i_request_granted,
    input  logic [QW-1:0]   i_spare_held,
    output logic [QW-1:0]   o_new_unit,
    output logic [1:0]      o_revoke_action,
    output logic            o_notify_shrink,
    output logic [QW-1:0]   o_extra_grant,
    output logic [1:0]      o_status
);

    t_cfg  r_cfg;
    t_cmd  cmd;
    t_stat stat;

    // config register file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.least_unit      <= LEAST_UNIT_RST;
            r_cfg.soft_least_unit <= SOFT_LEAST_UNIT_RST;
            r_cfg.slave_count     <= '0;
            r_cfg.block_resource  <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_LEAST_UNIT:      r_cfg.least_unit      <= i_cfg_data[QW-1:0];
                REG_SOFT_LEAST_UNIT: r_cfg.soft_least_unit <= i_cfg_data[QW-1:0];
                REG_SLAVE_COUNT:     r_cfg.slave_count     <= i_cfg_data[SW-1:0];
                REG_BLOCK_RESOURCE:  r_cfg.block_resource  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // sequencer
    qgus_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy),
        .o_done  (o_done)
    );

    // operand registers, arithmetic and result registers
    qgus_dp u_dp (
        .i_clk             (i_clk),
        .i_cfg             (r_cfg),
        .i_cmd             (cmd),
        .i_opcode          (i_opcode),
        .i_enforced        (i_enforced),
        .i_root_id         (i_root_id),
        .i_hard_limit      (i_hard_limit),
        .i_soft_limit      (i_soft_limit),
        .i_granted_total   (i_granted_total),
        .i_current_unit    (i_current_unit),
        .i_request_granted (i_request_granted),
        .i_spare_held      (i_spare_held),
        .o_stat            (stat),
        .o_new_unit        (o_new_unit),
        .o_revoke_action   (o_revoke_action),
        .o_notify_shrink   (o_notify_shrink),
        .o_extra_grant     (o_extra_grant),
        .o_status          (o_status)
    );

endmodule

// ===== hw/rtl/qgus_dp.sv =====
// ----------------------------------------------------------------------------
// qgus_dp
// datapath: operand registers, multiplier, adder/compare, bit-serial divider
// ----------------------------------------------------------------------------
module qgus_dp import qgus_pkg::*; (
    input  logic          i_clk,
    input  t_cfg          i_cfg,
    input  t_cmd          i_cmd,
    input  logic          i_opcode,
    input  logic          i_enforced,
    input  logic          i_root_id,
    input  logic [QW-1:0] i_hard_limit,
    input  logic [QW-1:0] i_soft_limit,
    input  logic [QW-1:0] i_granted_total,
    input  logic [QW-1:0] i_current_unit,
    input  logic [QW-1:0] i_request_granted,
    input  logic [QW-1:0] i_spare_held,
    output t_stat         o_stat,
    output logic [QW-1:0] o_new_unit,
    output logic [1:0]    o_revoke_action,
    output logic          o_notify_shrink,
    output logic [QW-1:0] o_extra_grant,
    output logic [1:0]    o_status
);

    logic            r_op, r_enf, r_root, r_dir;
    logic [QW-1:0]   r_hard, r_soft, r_tot, r_cur, r_got, r_spare;
    logic [QW-1:0]   r_unit, r_lim, r_cap, r_prod, r_sum;
    logic [REMW-1:0] r_rem;
    logic [QW-1:0]   r_new_unit, r_extra;
    logic [1:0]      r_revoke, r_status;
    logic            r_notify;

    logic            over;
    logic [QW-1:0]   lim_sel, six_p, half_p;
    logic            lim_ge_sum;
    logic [REMW-1:0] div_trial, div_d;
    logic            div_ge;

    // far over soft limit for block resources
    assign over    = i_cfg.block_resource && (r_tot > (r_soft + i_cfg.soft_least_unit));
    assign lim_sel = (r_soft != '0) ? (over ? r_hard : r_soft) : r_hard;
    assign six_p   = (r_prod << 2) + (r_prod << 1);
    assign half_p  = r_prod >> 1;
    assign lim_ge_sum = r_lim >= r_sum;

    assign div_d     = {1'b0, i_cfg.slave_count, 1'b0};
    assign div_trial = {r_rem[REMW-2:0], r_lim[QW-1]};
    assign div_ge    = div_trial >= div_d;

    always_comb begin
        o_stat.op            = r_op;
        o_stat.dir           = r_dir;
        o_stat.skip          = r_op ? (!r_enf || (r_cur == '0))
                                    : (!r_enf || r_root || (i_cfg.slave_count == '0));
        o_stat.nolim         = (r_soft == '0) && (r_hard == '0);
        o_stat.soft_set      = r_soft != '0;
        o_stat.lim_zero      = r_lim == '0;
        o_stat.tot_ge_lim    = r_tot >= r_lim;
        o_stat.decide_grow   = (r_unit == i_cfg.least_unit) || lim_ge_sum;
        o_stat.grow_go       = (r_unit != '0) && lim_ge_sum;
        o_stat.shrink_go     = (r_unit > i_cfg.least_unit) && !lim_ge_sum;
        o_stat.unit_zero     = r_unit == '0;
        o_stat.spare_ge_unit = r_spare >= r_unit;
        o_stat.left_gt_half  = r_lim > half_p;
        o_stat.unit_ne_least = r_unit != i_cfg.least_unit;
        o_stat.unit_ge_least = r_unit >= i_cfg.least_unit;
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd)
            CMD_LOAD: begin
                r_op    <= i_opcode;
                r_enf   <= i_enforced;
                r_root  <= i_root_id;
                r_hard  <= i_hard_limit;
                r_soft  <= i_soft_limit;
                r_tot   <= i_granted_total;
                r_cur   <= i_current_unit;
                r_got   <= i_request_granted;
                r_spare <= i_spare_held;
            end
            CMD_SETUP: begin
                r_dir <= 1'b0;
                r_cap <= ((r_soft != '0) && over) ? i_cfg.soft_least_unit : '0;
                if (r_op == OP_RESIZE) begin
                    r_lim  <= lim_sel;
                    r_unit <= (r_cur == '0) ? i_cfg.least_unit : r_cur;
                end else begin
                    r_lim  <= ((r_soft != '0) && (lim_sel == '0))
                              ? r_tot + i_cfg.soft_least_unit : lim_sel;
                    r_unit <= r_cur;
                end
            end
            CMD_MUL:      r_prod <= r_unit * QW'(i_cfg.slave_count);
            CMD_SUM:      r_sum  <= r_tot + (r_dir ? six_p : half_p);
            CMD_SET_GROW: r_dir  <= 1'b1;
            CMD_GROW:     r_unit <= r_unit << 2;
            CMD_SHRINK:   r_unit <= r_unit >> 2;
            CMD_DIV_INIT: r_rem  <= '0;
            CMD_DIV_STEP: begin
                r_rem  <= div_ge ? div_trial - div_d : div_trial;
                r_unit <= {r_unit[QW-2:0], div_ge};
                r_lim  <= r_lim << 1;
            end
            CMD_SET_CAP:  r_unit <= r_cap;
            CMD_CLAMP: begin
                if ((r_cap != '0) && (r_unit > r_cap)) begin
                    r_unit <= r_cap;
                end
            end
            CMD_SUB_TOT:  r_lim  <= r_lim - r_tot;
            CMD_MASK_GOT: r_got  <= r_got & (r_unit - QW'(1));
            CMD_SUB_HALF: r_lim  <= r_lim - half_p;
            CMD_GIVE:     r_prod <= (r_spare != '0) ? r_unit - r_spare : r_unit - r_got;
            CMD_FIN_SKIP, CMD_FIN_NOLIM, CMD_FIN_ZERO: begin
                r_new_unit <= r_cur;
                r_revoke   <= REV_KEEP;
                r_notify   <= 1'b0;
                r_extra    <= '0;
                r_status   <= (i_cmd == CMD_FIN_SKIP)  ? ST_SKIP :
                              (i_cmd == CMD_FIN_NOLIM) ? ST_NOLIM : ST_DONE;
            end
            CMD_FIN_RESIZE: begin
                r_extra  <= '0;
                r_status <= ST_DONE;
                if (r_unit == r_cur) begin
                    r_new_unit <= r_cur;
                    r_revoke   <= REV_KEEP;
                    r_notify   <= 1'b0;
                end else begin
                    r_new_unit <= r_unit;
                    r_notify   <= r_unit < r_cur;
                    r_revoke   <= ((r_unit > r_cur) && (r_unit == i_cfg.least_unit))
                                  ? REV_NOW : REV_CLEAR;
                end
            end
            CMD_FIN_EXP: begin
                r_new_unit <= r_cur;
                r_revoke   <= REV_KEEP;
                r_notify   <= 1'b0;
                r_extra    <= (r_prod < r_lim) ? r_prod : r_lim;
                r_status   <= ST_DONE;
            end
            default: ;
        endcase
    end

    assign o_new_unit      = r_new_unit;
    assign o_revoke_action = r_revoke;
    assign o_notify_shrink = r_notify;
    assign o_extra_grant   = r_extra;
    assign o_status        = r_status;

endmodule

// ===== hw/rtl/qgus_ctrl.sv =====
// ----------------------------------------------------------------------------
// qgus_ctrl
// sequencer: walks the resize and extra-grant flows over the datapath
// ----------------------------------------------------------------------------
module qgus_ctrl import qgus_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  o_busy,
    output logic  o_done
);

    typedef enum logic [14:0] {
        S_IDLE   = 15'b000000000000001,
        S_SETUP  = 15'b000000000000010,
        S_CHECK  = 15'b000000000000100,
        S_MUL    = 15'b000000000001000,
        S_SUM    = 15'b000000000010000,
        S_DECIDE = 15'b000000000100000,
        S_TEST   = 15'b000000001000000,
        S_DIV    = 15'b000000010000000,
        S_CLAMP  = 15'b000000100000000,
        S_FIN    = 15'b000001000000000,
        S_E_TOP  = 15'b000010000000000,
        S_E_DEC  = 15'b000100000000000,
        S_E_COND = 15'b001000000000000,
        S_E_GIVE = 15'b010000000000000,
        S_E_FIN  = 15'b100000000000000
    } t_state;

    t_state           r_state, n_state;
    logic             r_first, n_first;
    logic             r_done, n_done;
    logic [DCNTW-1:0] r_cnt, n_cnt;

    always_comb begin
        n_state = r_state;
        n_first = r_first;
        n_done  = 1'b0;
        n_cnt   = r_cnt;
        o_cmd   = CMD_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd   = CMD_LOAD;
                    n_state = S_SETUP;
                end
            end
            S_SETUP: begin
                o_cmd   = CMD_SETUP;
                n_first = 1'b1;
                n_state = S_CHECK;
            end
            S_CHECK: begin
                priority if (i_stat.skip) begin
                    o_cmd   = CMD_FIN_SKIP;
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else if (i_stat.op == OP_EXTRA) begin
                    if (i_stat.tot_ge_lim) begin
                        o_cmd   = CMD_FIN_ZERO;
                        n_done  = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        o_cmd   = CMD_SUB_TOT;
                        n_state = S_E_TOP;
                    end
                end else if (i_stat.nolim) begin
                    o_cmd   = CMD_FIN_NOLIM;
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else if (i_stat.soft_set && i_stat.lim_zero) begin
                    o_cmd   = CMD_SET_CAP;
                    n_state = S_FIN;
                end else begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd   = CMD_MUL;
                n_state = (i_stat.op == OP_EXTRA) ? S_E_DEC : S_SUM;
            end
            S_SUM: begin
                o_cmd   = CMD_SUM;
                n_state = r_first ? S_DECIDE : S_TEST;
            end
            S_DECIDE: begin
                n_first = 1'b0;
                if (i_stat.decide_grow) begin
                    o_cmd   = CMD_SET_GROW;
                    n_state = S_SUM;
                end else begin
                    n_state = S_TEST;
                end
            end
            S_TEST: begin
                priority if (i_stat.dir && i_stat.grow_go) begin
                    o_cmd   = CMD_GROW;
                    n_state = S_MUL;
                end else if (i_stat.dir && i_stat.unit_zero) begin
                    o_cmd   = CMD_DIV_INIT;
                    n_cnt   = '0;
                    n_state = S_DIV;
                end else if (!i_stat.dir && i_stat.shrink_go) begin
                    o_cmd   = CMD_SHRINK;
                    n_state = S_MUL;
                end else begin
                    n_state = S_CLAMP;
                end
            end
            S_DIV: begin
                o_cmd = CMD_DIV_STEP;
                n_cnt = r_cnt + DCNTW'(1);
                if (r_cnt == DCNTW'(QW - 1)) begin
                    n_state = S_CLAMP;
                end
            end
            S_CLAMP: begin
                o_cmd   = CMD_CLAMP;
                n_state = S_FIN;
            end
            S_FIN: begin
                o_cmd   = CMD_FIN_RESIZE;
                n_done  = 1'b1;
                n_state = S_IDLE;
            end
            S_E_TOP: begin
                if (i_stat.spare_ge_unit) begin
                    o_cmd   = CMD_FIN_ZERO;
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    o_cmd   = CMD_MASK_GOT;
                    n_state = S_MUL;
                end
            end
            S_E_DEC: begin
                priority if (i_stat.left_gt_half) begin
                    o_cmd   = CMD_SUB_HALF;
                    n_state = S_E_GIVE;
                end else if (i_stat.unit_ne_least) begin
                    o_cmd   = CMD_SHRINK;
                    n_state = S_E_COND;
                end else begin
                    n_state = S_E_GIVE;
                end
            end
            S_E_COND: begin
                if (i_stat.unit_ge_least) begin
                    n_state = S_E_TOP;
                end else begin
                    o_cmd   = CMD_FIN_ZERO;
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_E_GIVE: begin
                o_cmd   = CMD_GIVE;
                n_state = S_E_FIN;
            end
            S_E_FIN: begin
                o_cmd   = CMD_FIN_EXP;
                n_done  = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_first <= 1'b0;
            r_done  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_first <= n_first;
            r_done  <= n_done;
            r_cnt   <= n_cnt;
        end
    end

    assign o_busy = r_state != S_IDLE;
    assign o_done = r_done;

`ifndef NO_ASSERTIONS
    // a result beat always marks the return to idle
    a_fall_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_busy) |-> o_done) else $error("busy fell without a result beat");
    // result beats never come back to back
    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("two result beats in a row");
    // division only on the growing resize path
    a_div_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (i_stat.dir && (i_stat.op == OP_RESIZE)))
        else $error("divider run outside grow path");
    // a load of a new item is always followed by setup
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd == CMD_LOAD) |=> (r_state == S_SETUP))
        else $error("load not followed by setup");
`endif

endmodule
